[sv/tcpc_pkg.sv]
// ----------------------------------------------------------------------------
// tcpc_pkg
// Shared types and constants for the TCP checksum core with IPv4 pseudo-header.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcpc_pkg;

  // Protocol number of TCP, added as one pseudo-header word.
  localparam logic [15:0] TCP_PROTO = 16'd6;

  // One unit of work handed from the byte front end to the summing back end.
  // Every entry carries one 16-bit word (zero when there is none). The entry
  // that closes a segment also carries the pseudo-header data and status.
  typedef struct packed {
    logic [15:0] word;
    logic        last;
    logic        err;
    logic [15:0] len;
    logic [31:0] src;
    logic [31:0] dst;
  } tcpc_entry_t;

endpackage : tcpc_pkg

`default_nettype wire

[sv/tcpc_front.sv]
// ----------------------------------------------------------------------------
// tcpc_front
// Byte front end: pairs segment bytes into big-endian words, counts bytes,
// samples the addresses on the first byte and emits work entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcpc_front #(
  parameter int MAX_SEGMENT_BYTES = 65535
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_byte,
  input  wire logic [31:0]          source_address,
  input  wire logic [31:0]          target_address,
  output logic                      q_push,
  output tcpc_pkg::tcpc_entry_t     q_entry
);
  import tcpc_pkg::*;

  localparam int CW = $clog2(MAX_SEGMENT_BYTES + 2);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SEGMENT_BYTES);

  logic          inside_r;
  logic          inside_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [7:0]    held_r;
  logic [7:0]    held_nxt;
  logic [31:0]   src_r;
  logic [31:0]   dst_r;

  logic          first;
  logic [CW-1:0] cnt_cur;
  logic [CW-1:0] cnt_inc;
  logic [7:0]    held_cur;
  logic [31:0]   src_cur;
  logic [31:0]   dst_cur;
  logic          counted;
  logic          word_en;
  logic [15:0]   word;

  // Values seen by this byte; a new segment starts from cleared state.
  assign first    = !inside_r;
  assign cnt_cur  = first ? '0 : cnt_r;
  assign held_cur = first ? 8'h00 : held_r;
  assign src_cur  = first ? source_address : src_r;
  assign dst_cur  = first ? target_address : dst_r;
  assign cnt_inc  = cnt_cur + CW'(1);
  assign counted  = (cnt_cur < MAX_C);

  // Word assembly: an even byte is held as the high half, an odd byte
  // completes the word. A final even byte is padded with a zero low half.
  always_comb begin
    word_en  = 1'b0;
    word     = 16'h0000;
    held_nxt = held_cur;
    cnt_nxt  = MAX_C + CW'(1);
    if (counted) begin
      cnt_nxt = cnt_inc;
      if (!cnt_cur[0]) begin
        held_nxt = data_byte;
        word_en  = last_byte;
        word     = {data_byte, 8'h00};
      end else begin
        word_en = 1'b1;
        word    = {held_cur, data_byte};
      end
    end
  end

  assign inside_nxt = !last_byte;

  // Entry toward the queue.
  always_comb begin
    q_entry.word = word;
    q_entry.last = last_byte;
    q_entry.err  = !counted;
    q_entry.len  = counted ? 16'(cnt_inc) : 16'(MAX_SEGMENT_BYTES);
    q_entry.src  = src_cur;
    q_entry.dst  = dst_cur;
  end

  assign q_push = accept && (word_en || last_byte);

  // Segment control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else if (accept) begin
      inside_r <= inside_nxt;
    end
  end

  // Counter, held byte and sampled addresses.
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
      src_r  <= src_cur;
      dst_r  <= dst_cur;
    end
  end

endmodule : tcpc_front

`default_nettype wire

[sv/tcpc_queue.sv]
// ----------------------------------------------------------------------------
// tcpc_queue
// Short first-in first-out queue of work entries between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcpc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire tcpc_pkg::tcpc_entry_t wr_entry,
  output logic                       q_full,
  input  wire logic                  rd_en,
  output logic                       rd_valid,
  output tcpc_pkg::tcpc_entry_t      rd_entry
);
  import tcpc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  tcpc_entry_t   slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [NW-1:0] cnt_r;
  logic [NW-1:0] cnt_nxt;
  logic          do_wr;
  logic          do_rd;

  assign q_full   = (cnt_r == NW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_entry = slots_r[rd_ptr_r];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule : tcpc_queue

`default_nettype wire

[sv/tcpc_back.sv]
// ----------------------------------------------------------------------------
// tcpc_back
// Summing back end: one's complement word accumulator and a short finishing
// pipeline that adds the pseudo-header, folds carries and complements.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcpc_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  input  wire tcpc_pkg::tcpc_entry_t q_entry,
  output logic                       q_pop,
  input  wire logic                  pop,
  output logic                       empty,
  output logic [15:0]                checksum_value,
  output logic                       too_long,
  output logic [15:0]                segment_length
);
  import tcpc_pkg::*;

  logic        adv;
  logic        take;

  logic [15:0] acc_r;
  logic [15:0] acc_nxt;
  logic [16:0] acc_raw;
  logic [15:0] acc_sum;

  logic        f1_v_r;
  logic [15:0] f1_sum_r;
  logic [17:0] f1_addr_r;
  logic [16:0] f1_lenp_r;
  logic        f1_err_r;
  logic [15:0] f1_len_r;

  logic        f2_v_r;
  logic [19:0] f2_tot_r;
  logic        f2_err_r;
  logic [15:0] f2_len_r;

  logic        out_v_r;
  logic [15:0] out_chk_r;
  logic        out_err_r;
  logic [15:0] out_len_r;

  logic [16:0] fold1;
  logic [15:0] fold2;

  // The whole back end moves when the result register is free or drained.
  assign adv   = !out_v_r || pop;
  assign take  = adv && q_valid;
  assign q_pop = take;

  // End-around-carry add of the incoming word; cleared after a segment.
  assign acc_raw = {1'b0, acc_r} + {1'b0, q_entry.word};
  assign acc_sum = acc_raw[15:0] + {15'd0, acc_raw[16]};
  assign acc_nxt = q_entry.last ? 16'h0000 : acc_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 16'h0000;
    end else if (take) begin
      acc_r <= acc_nxt;
    end
  end

  // Stage one: segment sum, address words and length plus protocol.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= take && q_entry.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_sum_r  <= acc_sum;
      f1_addr_r <= 18'(q_entry.src[31:16]) + 18'(q_entry.src[15:0])
                 + 18'(q_entry.dst[31:16]) + 18'(q_entry.dst[15:0]);
      f1_lenp_r <= {1'b0, q_entry.len} + {1'b0, TCP_PROTO};
      f1_err_r  <= q_entry.err;
      f1_len_r  <= q_entry.len;
    end
  end

  // Stage two: plain total of the three partial sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_tot_r <= 20'(f1_sum_r) + 20'(f1_addr_r) + 20'(f1_lenp_r);
      f2_err_r <= f1_err_r;
      f2_len_r <= f1_len_r;
    end
  end

  // Two folds clear every carry of a 20-bit total.
  assign fold1 = {1'b0, f2_tot_r[15:0]} + 17'(f2_tot_r[19:16]);
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  // Result register, shown while valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_chk_r <= f2_err_r ? 16'h0000 : ~fold2;
      out_err_r <= f2_err_r;
      out_len_r <= f2_len_r;
    end
  end

  assign empty          = !out_v_r;
  assign checksum_value = out_chk_r;
  assign too_long       = out_err_r;
  assign segment_length = out_len_r;

endmodule : tcpc_back

`default_nettype wire

[sv/tcp_checksum_with_pseudo_header_core.sv]
// ----------------------------------------------------------------------------
// tcp_checksum_with_pseudo_header_core
// TCP checksum over a byte-serial segment and its IPv4 pseudo-header.
// ----------------------------------------------------------------------------
// The core takes one segment byte per cycle while full is low, and gives one
// result per segment when the byte marked last has gone through. The addresses
// are sampled with the first byte of each segment. A byte that completes a
// word, or closes a segment, is written into a work queue of QUEUE_DEPTH
// entries (four by default) at the clock edge that accepts it; the summing
// back end reads the queue head, whenever it is not halted, into the first of
// its three registered stages (stage one, stage two and the result register),
// and the result reaches the output ports through the later two. The back end
// adds one word per cycle, so the sustained rate is one byte per cycle; it only
// halts while a finished result is not popped, and the queue then absorbs
// bytes until it is full. A segment longer than MAX_SEGMENT_BYTES gives
// too_long with checksum 0 and segment_length at that maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcp_checksum_with_pseudo_header_core #(
  parameter int MAX_SEGMENT_BYTES = 65535,
  parameter int QUEUE_DEPTH       = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic [31:0] in_source_address,
  input  wire logic [31:0] in_target_address,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      out_checksum_value,
  output logic             out_too_long,
  output logic [15:0]      out_segment_length
);
  import tcpc_pkg::*;

  logic        accept;
  logic        q_push;
  tcpc_entry_t q_wr_entry;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  tcpc_entry_t q_rd_entry;

  // Input transfer.
  assign full   = q_full;
  assign accept = push && !q_full;

  tcpc_front #(
    .MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .data_byte      (in_data_byte),
    .last_byte      (in_last_byte),
    .source_address (in_source_address),
    .target_address (in_target_address),
    .q_push         (q_push),
    .q_entry        (q_wr_entry)
  );

  tcpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_entry (q_wr_entry),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_entry (q_rd_entry)
  );

  tcpc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_entry        (q_rd_entry),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .checksum_value (out_checksum_value),
    .too_long       (out_too_long),
    .segment_length (out_segment_length)
  );

endmodule : tcp_checksum_with_pseudo_header_core

`default_nettype wire

[sv/tcpc_checker.sv]
// ----------------------------------------------------------------------------
// tcpc_checker
// Port-level checks for the TCP checksum core, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcpc_checker #(
  parameter int MAX_SEGMENT_BYTES = 65535
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] out_checksum_value,
  input wire logic        out_too_long,
  input wire logic [15:0] out_segment_length
);

  // Reset leaves no result and room for input.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("core not idle after reset");

  // An overlong segment reports checksum zero and the maximum length.
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_too_long) |->
      (out_checksum_value == 16'h0000 &&
       out_segment_length == 16'(MAX_SEGMENT_BYTES)))
    else $error("overlong segment result malformed");

  // Every reported segment holds at least one byte.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_segment_length != 16'h0000))
    else $error("result with zero segment length");

  // A result that is not popped stays unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=>
      (!empty && $stable(out_checksum_value) && $stable(out_too_long) &&
       $stable(out_segment_length)))
    else $error("waiting result changed");

endmodule : tcpc_checker

bind tcp_checksum_with_pseudo_header_core tcpc_checker #(
  .MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES)
) u_tcpc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .full               (full),
  .empty              (empty),
  .pop                (pop),
  .out_checksum_value (out_checksum_value),
  .out_too_long       (out_too_long),
  .out_segment_length (out_segment_length)
);

`default_nettype wire
